// ===== hdl/mfb_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and fixed-point helpers of the perceptron engine
package mfb_pkg;

	localparam int MAX_IN  = 64;
	localparam int MAX_HID = 64;
	localparam int MAX_OUT = 16;
	localparam int W_DEPTH = MAX_HID * (MAX_IN + 1) + MAX_OUT * (MAX_HID + 1);
	localparam int VB      = 24;
	localparam int SIG_N   = 256;

	localparam int IN_AW  = $clog2(MAX_IN);
	localparam int HID_AW = $clog2(MAX_HID);
	localparam int OUT_AW = $clog2(MAX_OUT);
	localparam int W_AW   = $clog2(W_DEPTH);
	localparam int SIG_AW = $clog2(SIG_N);
	localparam int CNT_W  = $clog2(MAX_HID + 1);
	localparam int NO_W   = $clog2(MAX_OUT + 1);
	localparam int IDX_W  = 13;
	localparam int ACT_W  = 17;
	localparam int RATE_W = 17;
	localparam int MUL_W  = 25;
	localparam int PROD_W = 2 * MUL_W;
	localparam int RND_W  = PROD_W - 16;
	localparam int ACC_W  = 40;
	localparam int SAT_W  = 41;
	localparam int ONE_Q16   = 65536;
	localparam int EIGHT_Q16 = 524288;
	localparam int SIG_SH    = 20 - SIG_AW;

	localparam logic [2:0] CFG_N_INPUTS   = 3'd0;
	localparam logic [2:0] CFG_N_HIDDEN   = 3'd1;
	localparam logic [2:0] CFG_N_OUTPUTS  = 3'd2;
	localparam logic [2:0] CFG_RATE       = 3'd3;
	localparam logic [2:0] CFG_HIDDEN_BIAS = 3'd4;
	localparam logic [2:0] CFG_OUTPUT_BIAS = 3'd5;

	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_INPUT  = 2'd1;
	localparam logic [1:0] FUNC_TARGET = 2'd2;
	localparam logic [1:0] FUNC_NOP    = 2'd3;

	typedef struct packed {
		logic [1:0]          func;
		logic [IDX_W-1:0]    index;
		logic signed [VB-1:0] value;
		logic                last;
	} item_t;

	typedef struct packed {
		logic [3:0]       out_index;
		logic [ACT_W-1:0] out_value;
		logic             out_last;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0]     ni;
		logic [CNT_W-1:0]     nh;
		logic [NO_W-1:0]      no;
		logic [RATE_W-1:0]    rate;
		logic signed [VB-1:0] hbias;
		logic signed [VB-1:0] obias;
	} cfg_t;

	typedef enum logic [2:0] {
		MUL_W_ACT, MUL_DO_W, MUL_H_1MH, MUL_DER_SUM, MUL_RATE_HD, MUL_RATE_DO, MUL_SD_ACT
	} mul_sel_t;

	typedef enum logic [1:0] {ACT_IN, ACT_H, ACT_HB, ACT_OB} act_sel_t;

	typedef struct packed {
		logic              accept;
		logic              acc_clr;
		logic              acc_add;
		logic              sum_ld;
		logic              deriv_ld;
		logic              sd_ld;
		logic              mul_en;
		mul_sel_t          mul_sel;
		act_sel_t          act_sel;
		logic              w_we;
		logic              w_upd;
		logic [W_AW-1:0]   w_addr;
		logic              in_we;
		logic [IN_AW-1:0]  in_addr;
		logic              h_we;
		logic [HID_AW-1:0] h_addr;
		logic              o_we;
		logic [OUT_AW-1:0] o_addr;
		logic              out_last;
		logic              do_we;
		logic [OUT_AW-1:0] do_addr;
		logic              hd_we;
		logic [HID_AW-1:0] hd_addr;
	} cmd_t;

	typedef logic [ACT_W-1:0] sig_rom_t [SIG_N];

	// round half up, drop 16 fraction bits
	function automatic logic signed [RND_W-1:0] rnd16(logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + PROD_W'(32768);
		return t[PROD_W-1:16];
	endfunction

	function automatic logic signed [VB-1:0] sat_v(logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = SAT_W'((64'sd1 <<< (VB - 1)) - 64'sd1);
		lo = -hi - SAT_W'(1);
		if (v > hi)
			return hi[VB-1:0];
		else if (v < lo)
			return lo[VB-1:0];
		else
			return v[VB-1:0];
	endfunction

	// table entry at the bin centre, exp by series of t/16 then four squarings
	function automatic logic [ACT_W-1:0] sig_entry(int k);
		longint     c;
		logic [63:0] t, f, term, e, den, num, q, rem;
		logic       neg;
		c = (longint'(2 * k + 1) * EIGHT_Q16) / SIG_N - EIGHT_Q16;
		neg = (c < 0);
		t = neg ? 64'(-c) : 64'(c);
		f = t << 10;
		term = 64'd1 << 30;
		e = 64'd1 << 30;
		term = ((term * f) >> 30) / 64'd1;  e = e - term;
		term = ((term * f) >> 30) / 64'd2;  e = e + term;
		term = ((term * f) >> 30) / 64'd3;  e = e - term;
		term = ((term * f) >> 30) / 64'd4;  e = e + term;
		term = ((term * f) >> 30) / 64'd5;  e = e - term;
		term = ((term * f) >> 30) / 64'd6;  e = e + term;
		term = ((term * f) >> 30) / 64'd7;  e = e - term;
		term = ((term * f) >> 30) / 64'd8;  e = e + term;
		term = ((term * f) >> 30) / 64'd9;  e = e - term;
		term = ((term * f) >> 30) / 64'd10; e = e + term;
		term = ((term * f) >> 30) / 64'd11; e = e - term;
		term = ((term * f) >> 30) / 64'd12; e = e + term;
		for (int s = 0; s < 4; s++)
			e = (e * e + (64'd1 << 29)) >> 30;
		den = (64'd1 << 30) + e;
		num = (64'd1 << 46) + (den >> 1);
		q = '0;
		rem = '0;
		for (int b = 47; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				q[b] = 1'b1;
			end
		end
		return neg ? ACT_W'(64'd65536 - q) : q[ACT_W-1:0];
	endfunction

	function automatic sig_rom_t build_sig_rom();
		sig_rom_t r;
		for (int k = 0; k < SIG_N; k++)
			r[k] = sig_entry(k);
		return r;
	endfunction

	localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

// ===== hdl/mfb_cfg.sv =====
`timescale 1ns / 1ps
// configuration registers and their effective values
module mfb_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	output mfb_pkg::cfg_t      cfg
);
	import mfb_pkg::*;

	logic [6:0]           n_inputs_q, n_hidden_q;
	logic [4:0]           n_outputs_q;
	logic [16:0]          rate_q;
	logic signed [VB-1:0] hbias_q, obias_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_inputs_q  <= 7'd2;
			n_hidden_q  <= 7'd2;
			n_outputs_q <= 5'd1;
			rate_q      <= 17'd6554;
			hbias_q     <= VB'(65536);
			obias_q     <= VB'(65536);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_N_INPUTS:    n_inputs_q  <= cfg_data[6:0];
				CFG_N_HIDDEN:    n_hidden_q  <= cfg_data[6:0];
				CFG_N_OUTPUTS:   n_outputs_q <= cfg_data[4:0];
				CFG_RATE:        rate_q      <= cfg_data[16:0];
				CFG_HIDDEN_BIAS: hbias_q     <= cfg_data[VB-1:0];
				CFG_OUTPUT_BIAS: obias_q     <= cfg_data[VB-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, oversize clamps to the maximum
	always_comb begin
		cfg.ni = (n_inputs_q == '0) ? CNT_W'(1) :
			(n_inputs_q > 7'(MAX_IN)) ? CNT_W'(MAX_IN) : CNT_W'(n_inputs_q);
		cfg.nh = (n_hidden_q == '0) ? CNT_W'(1) :
			(n_hidden_q > 7'(MAX_HID)) ? CNT_W'(MAX_HID) : CNT_W'(n_hidden_q);
		cfg.no = (n_outputs_q == '0) ? NO_W'(1) :
			(n_outputs_q > 5'(MAX_OUT)) ? NO_W'(MAX_OUT) : NO_W'(n_outputs_q);
		cfg.rate  = (rate_q > 17'(ONE_Q16)) ? RATE_W'(ONE_Q16) : rate_q;
		cfg.hbias = hbias_q;
		cfg.obias = obias_q;
	end

endmodule

// ===== hdl/mfb_datapath.sv =====
`timescale 1ns / 1ps
// memories, shared multiplier, accumulator and sigmoid table
module mfb_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  mfb_pkg::item_t   item,
	input  mfb_pkg::cfg_t    cfg,
	input  mfb_pkg::cmd_t    cmd,
	output mfb_pkg::result_t result,
	output logic             result_valid
);
	import mfb_pkg::*;

	logic signed [VB-1:0]    w_mem [W_DEPTH];
	logic signed [VB-1:0]    in_mem [MAX_IN];
	logic [ACT_W-1:0]        h_mem [MAX_HID];
	logic [ACT_W-1:0]        o_mem [MAX_OUT];
	logic signed [VB-1:0]    do_mem [MAX_OUT];
	logic signed [VB-1:0]    hd_mem [MAX_HID];
	logic [MAX_HID-1:0]      h_vld_q;
	logic [MAX_OUT-1:0]      o_vld_q;

	logic signed [VB-1:0]    w_rd_q, in_rd_q, do_rd_q, hd_rd_q;
	logic [ACT_W-1:0]        h_rd_q, o_rd_q;
	logic                    h_rd_vld_q, o_rd_vld_q;

	item_t                   item_q;
	logic signed [PROD_W-1:0] mul_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [VB-1:0]    sum_q;
	logic signed [MUL_W-1:0] deriv_q, sd_q;
	result_t                 result_q;
	logic                    result_valid_q;

	logic [ACT_W-1:0]        h_act, o_act, sig_v;
	logic signed [MUL_W-1:0] act_v, mul_a, mul_b;
	logic signed [RND_W-1:0] rnd_v;
	logic signed [VB-1:0]    w_wdata, do_wdata, hd_wdata;

	function automatic logic [ACT_W-1:0] sig_of(logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] off;
		off = x + ACC_W'(EIGHT_Q16);
		if (off < 0)
			return SIG_ROM[0];
		else if (off >= ACC_W'(2 * EIGHT_Q16))
			return SIG_ROM[SIG_N-1];
		else
			return SIG_ROM[off[SIG_SH+SIG_AW-1:SIG_SH]];
	endfunction

	// never-written activations read as zero
	assign h_act = h_rd_vld_q ? h_rd_q : '0;
	assign o_act = o_rd_vld_q ? o_rd_q : '0;
	assign rnd_v = rnd16(mul_q);
	assign sig_v = sig_of(acc_q);

	assign w_wdata  = cmd.w_upd ? sat_v(SAT_W'(w_rd_q) + SAT_W'(rnd_v)) : item_q.value;
	assign do_wdata = sat_v(SAT_W'(item_q.value) - SAT_W'(signed'({1'b0, o_act})));
	assign hd_wdata = sat_v(SAT_W'(rnd_v));

	always_comb begin
		unique case (cmd.act_sel)
			ACT_IN:  act_v = MUL_W'(in_rd_q);
			ACT_H:   act_v = MUL_W'(signed'({1'b0, h_act}));
			ACT_HB:  act_v = MUL_W'(cfg.hbias);
			ACT_OB:  act_v = MUL_W'(cfg.obias);
			default: act_v = '0;
		endcase
	end

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_W_ACT: begin
				mul_a = MUL_W'(w_rd_q);
				mul_b = act_v;
			end
			MUL_DO_W: begin
				mul_a = MUL_W'(do_rd_q);
				mul_b = MUL_W'(w_rd_q);
			end
			MUL_H_1MH: begin
				mul_a = MUL_W'(signed'({1'b0, h_act}));
				mul_b = MUL_W'(signed'({1'b0, ACT_W'(ONE_Q16) - h_act}));
			end
			MUL_DER_SUM: begin
				mul_a = deriv_q;
				mul_b = MUL_W'(sum_q);
			end
			MUL_RATE_HD: begin
				mul_a = MUL_W'(signed'({1'b0, cfg.rate}));
				mul_b = MUL_W'(hd_rd_q);
			end
			MUL_RATE_DO: begin
				mul_a = MUL_W'(signed'({1'b0, cfg.rate}));
				mul_b = MUL_W'(do_rd_q);
			end
			MUL_SD_ACT: begin
				mul_a = sd_q;
				mul_b = act_v;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.w_we)
			w_mem[cmd.w_addr] <= w_wdata;
		w_rd_q <= w_mem[cmd.w_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.in_we)
			in_mem[cmd.in_addr] <= item_q.value;
		in_rd_q <= in_mem[cmd.in_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.h_we)
			h_mem[cmd.h_addr] <= sig_v;
		h_rd_q <= h_mem[cmd.h_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.o_we)
			o_mem[cmd.o_addr] <= sig_v;
		o_rd_q <= o_mem[cmd.o_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.do_we)
			do_mem[cmd.do_addr] <= do_wdata;
		do_rd_q <= do_mem[cmd.do_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.hd_we)
			hd_mem[cmd.hd_addr] <= hd_wdata;
		hd_rd_q <= hd_mem[cmd.hd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_vld_q        <= '0;
			o_vld_q        <= '0;
			h_rd_vld_q     <= 1'b0;
			o_rd_vld_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.h_we)
				h_vld_q[cmd.h_addr] <= 1'b1;
			if (cmd.o_we)
				o_vld_q[cmd.o_addr] <= 1'b1;
			h_rd_vld_q     <= h_vld_q[cmd.h_addr];
			o_rd_vld_q     <= o_vld_q[cmd.o_addr];
			result_valid_q <= cmd.o_we;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept)
			item_q <= item;
		if (cmd.mul_en)
			mul_q <= mul_a * mul_b;
		if (cmd.acc_clr)
			acc_q <= '0;
		else if (cmd.acc_add)
			acc_q <= acc_q + ACC_W'(rnd_v);
		if (cmd.sum_ld)
			sum_q <= sat_v(SAT_W'(acc_q));
		if (cmd.deriv_ld)
			deriv_q <= rnd_v[MUL_W-1:0];
		if (cmd.sd_ld)
			sd_q <= rnd_v[MUL_W-1:0];
		if (cmd.o_we) begin
			result_q.out_index <= 4'(cmd.o_addr);
			result_q.out_value <= sig_v;
			result_q.out_last  <= cmd.out_last;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

// ===== hdl/mfb_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer for item handling, forward pass and backpropagation
module mfb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  mfb_pkg::item_t item,
	input  mfb_pkg::cfg_t  cfg,
	output logic           busy,
	output mfb_pkg::cmd_t  cmd
);
	import mfb_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_ITEM, S_TGT,
		S_F_RD, S_F_MUL, S_F_ACC, S_F_SIG,
		S_BH_RD, S_BH_MUL, S_BH_ACC, S_BD_1, S_BD_2, S_BD_3, S_BD_4,
		S_U_SD0, S_U_SD1, S_U_SD2, S_U_RD, S_U_MUL, S_U_WR
	} state_t;

	state_t           state_q;
	logic             layer_q, last_q;
	logic [1:0]       func_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] outer_q, inner_q;
	logic [W_AW-1:0]  addr_q, ptr_q;

	logic [CNT_W-1:0] lim_in, lim_out_m1, nh_m1, no_m1;
	logic [W_AW-1:0]  obase, stride;
	act_sel_t         act_sel;

	assign nh_m1      = cfg.nh - CNT_W'(1);
	assign no_m1      = CNT_W'(cfg.no) - CNT_W'(1);
	assign lim_in     = layer_q ? cfg.nh : cfg.ni;
	assign lim_out_m1 = layer_q ? no_m1 : nh_m1;
	assign obase      = W_AW'(W_AW'(cfg.nh) * (W_AW'(cfg.ni) + W_AW'(1)));
	assign stride     = W_AW'(cfg.nh) + W_AW'(1);
	// the last element of every neuron is its bias
	assign act_sel    = (inner_q == lim_in) ? (layer_q ? ACT_OB : ACT_HB)
	                                        : (layer_q ? ACT_H : ACT_IN);
	assign busy       = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.mul_sel = MUL_W_ACT;
		cmd.act_sel = act_sel;
		cmd.w_addr  = addr_q;
		cmd.in_addr = inner_q[IN_AW-1:0];
		cmd.h_addr  = inner_q[HID_AW-1:0];
		cmd.o_addr  = outer_q[OUT_AW-1:0];
		cmd.do_addr = outer_q[OUT_AW-1:0];
		cmd.hd_addr = outer_q[HID_AW-1:0];
		unique case (state_q)
			S_IDLE: cmd.accept = start;
			S_ITEM: begin
				cmd.acc_clr = 1'b1;
				cmd.w_addr  = idx_q[W_AW-1:0];
				cmd.in_addr = idx_q[IN_AW-1:0];
				cmd.o_addr  = idx_q[OUT_AW-1:0];
				cmd.do_addr = idx_q[OUT_AW-1:0];
				cmd.w_we    = (func_q == FUNC_LOAD) && (idx_q < IDX_W'(W_DEPTH));
				cmd.in_we   = (func_q == FUNC_INPUT) && (idx_q < IDX_W'(MAX_IN));
			end
			S_TGT: begin
				cmd.o_addr  = idx_q[OUT_AW-1:0];
				cmd.do_addr = idx_q[OUT_AW-1:0];
				cmd.do_we   = (idx_q < IDX_W'(MAX_OUT));
			end
			S_F_RD: ;
			S_F_MUL: cmd.mul_en = 1'b1;
			S_F_ACC: cmd.acc_add = 1'b1;
			S_F_SIG: begin
				cmd.acc_clr  = 1'b1;
				cmd.h_addr   = outer_q[HID_AW-1:0];
				cmd.h_we     = !layer_q;
				cmd.o_we     = layer_q;
				cmd.out_last = (outer_q == lim_out_m1);
			end
			S_BH_RD, S_BH_MUL, S_BH_ACC: begin
				cmd.w_addr  = ptr_q;
				cmd.do_addr = inner_q[OUT_AW-1:0];
				cmd.h_addr  = outer_q[HID_AW-1:0];
				cmd.mul_sel = MUL_DO_W;
				cmd.mul_en  = (state_q == S_BH_MUL);
				cmd.acc_add = (state_q == S_BH_ACC);
			end
			S_BD_1: begin
				cmd.h_addr  = outer_q[HID_AW-1:0];
				cmd.sum_ld  = 1'b1;
				cmd.mul_sel = MUL_H_1MH;
				cmd.mul_en  = 1'b1;
			end
			S_BD_2: begin
				cmd.h_addr   = outer_q[HID_AW-1:0];
				cmd.deriv_ld = 1'b1;
			end
			S_BD_3: begin
				cmd.mul_sel = MUL_DER_SUM;
				cmd.mul_en  = 1'b1;
			end
			S_BD_4: begin
				cmd.hd_we   = 1'b1;
				cmd.acc_clr = 1'b1;
			end
			S_U_SD0: ;
			S_U_SD1: begin
				cmd.mul_sel = layer_q ? MUL_RATE_DO : MUL_RATE_HD;
				cmd.mul_en  = 1'b1;
			end
			S_U_SD2: cmd.sd_ld = 1'b1;
			S_U_RD: ;
			S_U_MUL: begin
				cmd.mul_sel = MUL_SD_ACT;
				cmd.mul_en  = 1'b1;
			end
			S_U_WR: begin
				cmd.w_we  = 1'b1;
				cmd.w_upd = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			layer_q <= 1'b0;
			last_q  <= 1'b0;
			func_q  <= FUNC_LOAD;
			idx_q   <= '0;
			outer_q <= '0;
			inner_q <= '0;
			addr_q  <= '0;
			ptr_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) begin
					func_q  <= item.func;
					idx_q   <= item.index;
					last_q  <= item.last;
					state_q <= S_ITEM;
				end
				S_ITEM: begin
					layer_q <= 1'b0;
					outer_q <= '0;
					inner_q <= '0;
					addr_q  <= '0;
					if (func_q == FUNC_INPUT)
						state_q <= last_q ? S_F_RD : S_IDLE;
					else if (func_q == FUNC_TARGET)
						state_q <= S_TGT;
					else
						state_q <= S_IDLE;
				end
				S_TGT: begin
					ptr_q   <= obase;
					state_q <= last_q ? S_BH_RD : S_IDLE;
				end
				S_F_RD:  state_q <= S_F_MUL;
				S_F_MUL: state_q <= S_F_ACC;
				S_F_ACC: begin
					addr_q <= addr_q + W_AW'(1);
					if (inner_q == lim_in) begin
						state_q <= S_F_SIG;
					end else begin
						inner_q <= inner_q + CNT_W'(1);
						state_q <= S_F_RD;
					end
				end
				S_F_SIG: begin
					inner_q <= '0;
					if (outer_q == lim_out_m1) begin
						outer_q <= '0;
						layer_q <= 1'b1;
						state_q <= layer_q ? S_IDLE : S_F_RD;
					end else begin
						outer_q <= outer_q + CNT_W'(1);
						state_q <= S_F_RD;
					end
				end
				S_BH_RD:  state_q <= S_BH_MUL;
				S_BH_MUL: state_q <= S_BH_ACC;
				S_BH_ACC: begin
					ptr_q <= ptr_q + stride;
					if (inner_q == no_m1) begin
						state_q <= S_BD_1;
					end else begin
						inner_q <= inner_q + CNT_W'(1);
						state_q <= S_BH_RD;
					end
				end
				S_BD_1: state_q <= S_BD_2;
				S_BD_2: state_q <= S_BD_3;
				S_BD_3: state_q <= S_BD_4;
				S_BD_4: begin
					inner_q <= '0;
					if (outer_q == nh_m1) begin
						outer_q <= '0;
						layer_q <= 1'b0;
						addr_q  <= '0;
						state_q <= S_U_SD0;
					end else begin
						outer_q <= outer_q + CNT_W'(1);
						ptr_q   <= obase + W_AW'(outer_q) + W_AW'(1);
						state_q <= S_BH_RD;
					end
				end
				S_U_SD0: state_q <= S_U_SD1;
				S_U_SD1: state_q <= S_U_SD2;
				S_U_SD2: begin
					inner_q <= '0;
					state_q <= S_U_RD;
				end
				S_U_RD:  state_q <= S_U_MUL;
				S_U_MUL: state_q <= S_U_WR;
				S_U_WR: begin
					addr_q <= addr_q + W_AW'(1);
					if (inner_q == lim_in) begin
						if (outer_q == lim_out_m1) begin
							outer_q <= '0;
							layer_q <= 1'b1;
							state_q <= layer_q ? S_IDLE : S_U_SD0;
						end else begin
							outer_q <= outer_q + CNT_W'(1);
							state_q <= S_U_SD0;
						end
					end else begin
						inner_q <= inner_q + CNT_W'(1);
						state_q <= S_U_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/mlp_forward_backprop.sv =====
`timescale 1ns / 1ps
// Three-layer perceptron engine: one shared multiply-accumulate walks the weight memory.
// Weight load, plain input and target items are written when their index is in range. The last
// input item starts a forward pass, outputs strobed one per output neuron. The last target item
// starts a backpropagation step that updates every weight of the network.
// One item at a time: start is accepted only while busy is low; results cannot be stalled.
// Asynchronous active-low reset: registers to defaults, activations read as zero.
module mlp_forward_backprop (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mfb_pkg::item_t   item,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [23:0]      cfg_data,
	output mfb_pkg::result_t result,
	output logic             result_valid
);
	import mfb_pkg::*;

	cfg_t cfg;
	cmd_t cmd;

	mfb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mfb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.cfg    (cfg),
		.busy   (busy),
		.cmd    (cmd)
	);

	mfb_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg          (cfg),
		.cmd          (cmd),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

// ===== sim/mfb_checker.sv =====
`timescale 1ns / 1ps
// checker: watches the item, config and result channels, predicts activations and compares
module mfb_checker
	import mfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  item_t       item,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  result_t     result,
	input  logic        result_valid,
	output int          fail_count,
	output int          pending
);

	longint wts [W_DEPTH];
	longint in_act [MAX_IN];
	longint hid_act [MAX_HID];
	longint out_act [MAX_OUT];
	longint out_dl [MAX_OUT];
	longint hid_dl [MAX_HID];
	longint sig_tab [SIG_N];

	int unsigned reg_ni, reg_nh, reg_no, reg_rate;
	longint      reg_hb, reg_ob;

	result_t act_due [$];

	function automatic longint rnd_q16(longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	function automatic longint clip24(longint v);
		if (v > 64'sd8388607)
			return 64'sd8388607;
		if (v < -64'sd8388608)
			return -64'sd8388608;
		return v;
	endfunction

	function automatic int eff_size(int unsigned v, int unsigned lim);
		if (v == 0)
			return 1;
		return (v > lim) ? lim : v;
	endfunction

	// exp(-t), Q0.30, from a 12 term series of t/16 squared four times
	function automatic longint unsigned exp_q30(longint unsigned t);
		longint unsigned f, term, e;
		longint acc;
		f = t << 10;
		term = 64'd1 << 30;
		acc = 64'sd1 << 30;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * f) >> 30) / longint'(k);
			if (k % 2)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		e = acc;
		for (int s = 0; s < 4; s++)
			e = (e * e + (64'd1 << 29)) >> 30;
		return e;
	endfunction

	function automatic longint sig_at_centre(int k);
		longint c;
		longint unsigned t, den, s;
		c = (longint'(2 * k + 1) * EIGHT_Q16) / SIG_N - EIGHT_Q16;
		t = (c < 0) ? -c : c;
		den = (64'd1 << 30) + exp_q30(t);
		s = ((64'd1 << 46) + (den >> 1)) / den;
		return (c < 0) ? ONE_Q16 - longint'(s) : longint'(s);
	endfunction

	function automatic longint squash(longint x);
		if (x < -EIGHT_Q16)
			return sig_tab[0];
		if (x >= EIGHT_Q16)
			return sig_tab[SIG_N-1];
		return sig_tab[((x + EIGHT_Q16) * SIG_N) >>> 20];
	endfunction

	function automatic longint wstep(longint rate, longint dl, longint act);
		return rnd_q16(rnd_q16(rate * dl) * act);
	endfunction

	initial begin
		for (int k = 0; k < SIG_N; k++)
			sig_tab[k] = sig_at_centre(k);
	end

	task automatic run_forward();
		int ni, nh, no, obase;
		longint acc;
		result_t r;
		ni = eff_size(reg_ni, MAX_IN);
		nh = eff_size(reg_nh, MAX_HID);
		no = eff_size(reg_no, MAX_OUT);
		obase = nh * (ni + 1);
		for (int h = 0; h < nh; h++) begin
			acc = 0;
			for (int i = 0; i < ni; i++)
				acc += rnd_q16(wts[h*(ni+1)+i] * in_act[i]);
			acc += rnd_q16(wts[h*(ni+1)+ni] * reg_hb);
			hid_act[h] = squash(acc);
		end
		for (int o = 0; o < no; o++) begin
			acc = 0;
			for (int h = 0; h < nh; h++)
				acc += rnd_q16(wts[obase+o*(nh+1)+h] * hid_act[h]);
			acc += rnd_q16(wts[obase+o*(nh+1)+nh] * reg_ob);
			out_act[o] = squash(acc);
			r.out_index = o[3:0];
			r.out_value = out_act[o][ACT_W-1:0];
			r.out_last = (o + 1 == no);
			act_due.push_back(r);
		end
	endtask

	task automatic run_backprop();
		int ni, nh, no, obase;
		longint rate, sum, der;
		ni = eff_size(reg_ni, MAX_IN);
		nh = eff_size(reg_nh, MAX_HID);
		no = eff_size(reg_no, MAX_OUT);
		obase = nh * (ni + 1);
		rate = (reg_rate > ONE_Q16) ? ONE_Q16 : reg_rate;
		// hidden deltas use the weights from before this step
		for (int h = 0; h < nh; h++) begin
			sum = 0;
			for (int o = 0; o < no; o++)
				sum += rnd_q16(out_dl[o] * wts[obase+o*(nh+1)+h]);
			sum = clip24(sum);
			der = rnd_q16(hid_act[h] * (ONE_Q16 - hid_act[h]));
			hid_dl[h] = clip24(rnd_q16(der * sum));
		end
		for (int h = 0; h < nh; h++) begin
			for (int i = 0; i < ni; i++)
				wts[h*(ni+1)+i] = clip24(wts[h*(ni+1)+i] + wstep(rate, hid_dl[h], in_act[i]));
			wts[h*(ni+1)+ni] = clip24(wts[h*(ni+1)+ni] + wstep(rate, hid_dl[h], reg_hb));
		end
		for (int o = 0; o < no; o++) begin
			for (int h = 0; h < nh; h++)
				wts[obase+o*(nh+1)+h] = clip24(wts[obase+o*(nh+1)+h]
					+ wstep(rate, out_dl[o], hid_act[h]));
			wts[obase+o*(nh+1)+nh] = clip24(wts[obase+o*(nh+1)+nh]
				+ wstep(rate, out_dl[o], reg_ob));
		end
	endtask

	task automatic report(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		longint v;
		if (!arst_n) begin
			reg_ni = 2;
			reg_nh = 2;
			reg_no = 1;
			reg_rate = 6554;
			reg_hb = 65536;
			reg_ob = 65536;
			foreach (hid_act[i]) hid_act[i] = 0;
			foreach (out_act[i]) out_act[i] = 0;
			act_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_N_INPUTS:    reg_ni = cfg_data[6:0];
					CFG_N_HIDDEN:    reg_nh = cfg_data[6:0];
					CFG_N_OUTPUTS:   reg_no = cfg_data[4:0];
					CFG_RATE:        reg_rate = cfg_data[16:0];
					CFG_HIDDEN_BIAS: reg_hb = longint'($signed(cfg_data));
					CFG_OUTPUT_BIAS: reg_ob = longint'($signed(cfg_data));
					default: ;
				endcase
			end
			if (result_valid) begin
				if (act_due.size() == 0) begin
					report("unexpected result, out_value", result.out_value, -1);
				end else begin
					want = act_due.pop_front();
					if (result.out_index !== want.out_index)
						report("out_index", result.out_index, want.out_index);
					if (result.out_value !== want.out_value)
						report("out_value", result.out_value, want.out_value);
					if (result.out_last !== want.out_last)
						report("out_last", result.out_last, want.out_last);
				end
			end
			if (start && !busy) begin
				v = longint'($signed(item.value));
				case (item.func)
					FUNC_LOAD: begin
						if (item.index < W_DEPTH)
							wts[item.index] = v;
					end
					FUNC_INPUT: begin
						if (item.index < MAX_IN)
							in_act[item.index] = v;
						if (item.last)
							run_forward();
					end
					FUNC_TARGET: begin
						if (item.index < MAX_OUT)
							out_dl[item.index] = clip24(v - out_act[item.index]);
						if (item.last)
							run_backprop();
					end
					default: ;
				endcase
			end
		end
		pending = act_due.size();
	end

endmodule

// ===== sim/mlp_forward_backprop_tb.sv =====
`timescale 1ns / 1ps
// testbench top: stimulus for the perceptron engine and the final verdict
module mlp_forward_backprop_tb;
	import mfb_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       item;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;
	result_t     result;
	logic        result_valid;
	int          fail_count;
	int          pending;
	int          cycles;
	int          send_idle_pct;
	int          cur_ni, cur_nh, cur_no;
	int          w_mark;
	bit          in_wr [MAX_IN];
	bit          dl_wr [MAX_OUT];

	mlp_forward_backprop dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result(result), .result_valid(result_valid)
	);

	mfb_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result(result), .result_valid(result_valid),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("mlp_forward_backprop_tb failed");
			$finish;
		end
	end

	function automatic int eff_size(int v, int lim);
		if (v == 0)
			return 1;
		return (v > lim) ? lim : v;
	endfunction

	function automatic logic [23:0] rand_act();
		if ($urandom_range(0, 7) == 0)
			return 24'($urandom);
		return 24'($urandom_range(0, 262144) - 131072);
	endfunction

	function automatic logic [23:0] rand_weight();
		if ($urandom_range(0, 9) == 0)
			return 24'($urandom);
		return 24'($urandom_range(0, 131072) - 65536);
	endfunction

	// one item; start stays high afterwards unless the next call idles
	task automatic send(logic [1:0] fn, int idx, logic [23:0] val, bit lst);
		bit took;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		item <= '{func: fn, index: IDX_W'(idx), value: val, last: lst};
		do begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic settle();
		bit quiet;
		start <= 1'b0;
		do begin
			@(negedge clk);
			quiet = (pending == 0) && !busy;
			@(posedge clk);
		end while (!quiet);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		bit took;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
	endtask

	// addresses below the mark already hold weights from earlier loads
	task automatic load_weights();
		int n;
		n = cur_nh * (cur_ni + 1) + cur_no * (cur_nh + 1);
		for (int a = w_mark; a < n; a++)
			send(FUNC_LOAD, a, rand_weight(), 1'b0);
		if (n > w_mark)
			w_mark = n;
	endtask

	task automatic set_sizes(int ni, int nh, int no, int rate, int hb, int ob);
		settle();
		write_reg(CFG_N_INPUTS, 24'(ni));
		write_reg(CFG_N_HIDDEN, 24'(nh));
		write_reg(CFG_N_OUTPUTS, 24'(no));
		write_reg(CFG_RATE, 24'(rate));
		write_reg(CFG_HIDDEN_BIAS, 24'(hb));
		write_reg(CFG_OUTPUT_BIAS, 24'(ob));
		cfg_valid <= 1'b0;
		cur_ni = eff_size(ni & 127, MAX_IN);
		cur_nh = eff_size(nh & 127, MAX_HID);
		cur_no = eff_size(no & 31, MAX_OUT);
		load_weights();
	endtask

	// every element presented once in shuffled order, last on the final one
	task automatic present_all(logic [1:0] fn, int n);
		int order [MAX_IN];
		int j, t;
		for (int i = 0; i < n; i++)
			order[i] = i;
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < n; i++) begin
			if (fn == FUNC_INPUT) begin
				send(fn, order[i], rand_act(), i == n - 1);
				in_wr[order[i]] = 1'b1;
			end else begin
				send(fn, order[i], 24'($urandom_range(0, 65536)), i == n - 1);
				dl_wr[order[i]] = 1'b1;
			end
		end
	endtask

	function automatic bit ready_for(logic [1:0] fn);
		if (fn == FUNC_INPUT) begin
			for (int i = 0; i < cur_ni; i++)
				if (!in_wr[i])
					return 1'b0;
		end else begin
			for (int i = 0; i < cur_no; i++)
				if (!dl_wr[i])
					return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic random_burst();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick <= 3) begin
			present_all(FUNC_INPUT, cur_ni);
		end else if (pick <= 5) begin
			present_all(FUNC_TARGET, cur_no);
		end else if (pick == 6) begin
			repeat ($urandom_range(1, 3))
				send(FUNC_LOAD, $urandom_range(0, W_DEPTH - 1), rand_weight(), $urandom);
		end else if (pick == 7) begin
			case ($urandom_range(0, 2))
				0: send(FUNC_NOP, $urandom, 24'($urandom), $urandom);
				1: send(FUNC_LOAD, $urandom_range(W_DEPTH, 8191), 24'($urandom), $urandom);
				default: send(FUNC_TARGET, $urandom_range(MAX_OUT, 8191), 24'($urandom), 1'b0);
			endcase
		end else if (pick == 8) begin
			// partial element set, no pass started
			repeat ($urandom_range(1, 3)) begin
				send(FUNC_INPUT, $urandom_range(0, MAX_IN - 1), rand_act(), 1'b0);
			end
		end else begin
			// out of range index still starts the pass
			if (ready_for(FUNC_INPUT))
				send(FUNC_INPUT, $urandom_range(MAX_IN, 8191), 24'($urandom), 1'b1);
			if (ready_for(FUNC_TARGET))
				send(FUNC_TARGET, $urandom_range(MAX_OUT, 8191), 24'($urandom), 1'b1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycles = 0;
		send_idle_pct = 28;
		cur_ni = 2;
		cur_nh = 2;
		cur_no = 1;
		w_mark = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset sizes 2-2-1, extreme weights and values
		send(FUNC_LOAD, 0, 24'h7fffff, 1'b0);
		send(FUNC_LOAD, 1, 24'h800000, 1'b0);
		send(FUNC_LOAD, 2, 24'h000000, 1'b0);
		send(FUNC_LOAD, 3, 24'h010000, 1'b0);
		send(FUNC_LOAD, 4, 24'hff0000, 1'b0);
		send(FUNC_LOAD, 5, 24'h008000, 1'b1);
		send(FUNC_LOAD, 6, 24'h020000, 1'b0);
		send(FUNC_LOAD, 7, 24'hfe0000, 1'b0);
		send(FUNC_LOAD, 8, 24'h7fffff, 1'b0);
		w_mark = 9;
		send(FUNC_INPUT, 0, 24'h7fffff, 1'b0);
		send(FUNC_INPUT, 1, 24'h800000, 1'b1);
		send(FUNC_TARGET, 0, 24'h800000, 1'b1);
		send(FUNC_INPUT, 1, 24'h000000, 1'b1);
		send(FUNC_TARGET, 0, 24'h7fffff, 1'b1);
		send(FUNC_INPUT, 0, 24'h010000, 1'b1);
		send(FUNC_NOP, 8191, 24'hffffff, 1'b1);
		send(FUNC_LOAD, 8191, 24'h123456, 1'b1);
		send(FUNC_INPUT, 8191, 24'h7fffff, 1'b1);
		send(FUNC_TARGET, 8191, 24'h800000, 1'b1);
		send(FUNC_TARGET, 0, 24'h010000, 1'b1);
		send(FUNC_INPUT, 63, 24'h400000, 1'b1);
		in_wr[0] = 1'b1;
		in_wr[1] = 1'b1;
		in_wr[63] = 1'b1;
		dl_wr[0] = 1'b1;

		for (int p = 0; p < 10; p++) begin
			case (p)
				0: set_sizes(1, 1, 1, 0, -8388608, 8388607);
				1: set_sizes(64, 1, 1, 65536, 8388607, -8388608);
				2: set_sizes(1, 64, 1, 131071, 65536, 65536);
				3: set_sizes(1, 1, 16, $urandom_range(0, 131071), $urandom, $urandom);
				4: set_sizes(0, 0, 0, $urandom_range(0, 65536), $urandom, $urandom);
				5: set_sizes(127, 2, 31, $urandom_range(0, 65536), 65536, -65536);
				default: set_sizes($urandom_range(1, 5), $urandom_range(1, 6),
					$urandom_range(1, 4), $urandom_range(0, 65536),
					$urandom_range(0, 262144) - 131072, $urandom_range(0, 262144) - 131072);
			endcase
			send_idle_pct = (p < 3) ? 28 : ((p < 6) ? 88 : 0);
			// one full forward pass and one training step per size set
			present_all(FUNC_INPUT, cur_ni);
			present_all(FUNC_TARGET, cur_no);
			repeat ((cur_ni > 8) ? 0 : 5) random_burst();
		end

		settle();
		if (fail_count == 0)
			$display("mlp_forward_backprop_tb passed");
		else
			$display("mlp_forward_backprop_tb failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/mfb_pkg.sv
hdl/mfb_cfg.sv
hdl/mfb_datapath.sv
hdl/mfb_ctrl.sv
hdl/mlp_forward_backprop.sv
sim/mfb_checker.sv
sim/mlp_forward_backprop_tb.sv
